>>> sv/nectx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nectx_pkg
// Shared types, constants and helpers of the NEC IR transmitter.
// ----------------------------------------------------------------------------
package nectx_pkg;

    localparam int unsigned FRAME_BITS = 32;
    localparam int unsigned BIT_IDX_W  = 6;
    localparam int unsigned TICK_W     = 16;
    localparam int unsigned CYCLE_W    = 10;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned OUT_DATA_W = 40;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LEAD_MARK  = 3'd1,
        PH_LEAD_SPACE = 3'd2,
        PH_BIT_MARK   = 3'd3,
        PH_BIT_SPACE  = 3'd4,
        PH_STOP_MARK  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE          = 2'd0,
        ST_STARTED       = 2'd1,
        ST_REJ_DISABLED  = 2'd2,
        ST_REJ_BUSY      = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE        = 3'd0,
        REG_CARRIER_PER   = 3'd1,
        REG_CARRIER_HIGH  = 3'd2,
        REG_LEAD_MARK     = 3'd3,
        REG_LEAD_SPACE    = 3'd4,
        REG_BIT_MARK      = 3'd5,
        REG_ZERO_SPACE    = 3'd6,
        REG_ONE_SPACE     = 3'd7
    } cfg_index_t;

    localparam logic [7:0]  RST_CARRIER_PER  = 8'd26;
    localparam logic [7:0]  RST_CARRIER_HIGH = 8'd8;
    localparam logic [9:0]  RST_LEAD_MARK    = 10'd346;
    localparam logic [15:0] RST_LEAD_SPACE   = 16'd4500;
    localparam logic [9:0]  RST_BIT_MARK     = 10'd21;
    localparam logic [15:0] RST_ZERO_SPACE   = 16'd560;
    localparam logic [15:0] RST_ONE_SPACE    = 16'd1690;

    typedef struct packed {
        logic        enable;
        logic [7:0]  carrier_period_us;
        logic [7:0]  carrier_high_us;
        logic [9:0]  leader_mark_cycles;
        logic [15:0] leader_space_us;
        logic [9:0]  bit_mark_cycles;
        logic [15:0] zero_space_us;
        logic [15:0] one_space_us;
    } cfg_t;

    typedef struct packed {
        logic        ir_level;
        logic        busy_res;
        status_t     status;
        logic [31:0] last_code_out;
    } result_t;

    // Reorders the code into send order: byte 31:24 first, each byte LSB first.
    function automatic logic [FRAME_BITS-1:0] frame_order(input logic [FRAME_BITS-1:0] code);
        logic [FRAME_BITS-1:0] seq;
        for (int j = 0; j < FRAME_BITS; j++) begin
            seq[j] = code[(3 - j / 8) * 8 + (j % 8)];
        end
        return seq;
    endfunction

    function automatic logic is_mark(input phase_t p);
        return (p == PH_LEAD_MARK) || (p == PH_BIT_MARK) || (p == PH_STOP_MARK);
    endfunction

endpackage

>>> sv/nectx_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nectx_engine
// Frame state and per-item update: one tick or start item per enabled cycle.
// ----------------------------------------------------------------------------
module nectx_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                op,
    input  logic [31:0]         code,
    input  nectx_pkg::cfg_t     cfg,
    output nectx_pkg::result_t  res
);

    nectx_pkg::phase_t                        phase_reg, phase_next;
    logic [nectx_pkg::TICK_W-1:0]             tick_reg, tick_next;
    logic [nectx_pkg::CYCLE_W-1:0]            cycle_reg, cycle_next;
    logic [nectx_pkg::BIT_IDX_W-1:0]          bit_reg, bit_next;
    logic [31:0]                              frame_reg, frame_next;
    logic [31:0]                              last_reg, last_next;

    nectx_pkg::phase_t                        req_ph;
    logic [nectx_pkg::BIT_IDX_W-1:0]          req_b;
    logic                                     req_en;
    nectx_pkg::phase_t                        ent_ph;
    logic [nectx_pkg::BIT_IDX_W-1:0]          ent_b;

    logic [31:0]                              seq;
    logic [31:0]                              skip;
    logic [31:0]                              cand;
    logic                                     found;
    logic [4:0]                               first;
    logic [nectx_pkg::BIT_IDX_W-1:0]          b_inc;
    logic                                     accept_start;
    nectx_pkg::status_t                       status;
    logic                                     level_cur;
    logic                                     level_next;
    logic [nectx_pkg::TICK_W:0]               tick_inc;
    logic [nectx_pkg::CYCLE_W:0]              cycle_inc;
    logic [15:0]                              space_len;
    logic [9:0]                               mark_len;

    assign accept_start = op && cfg.enable && (phase_reg == nectx_pkg::PH_IDLE);
    assign seq          = nectx_pkg::frame_order(accept_start ? code : frame_reg);

    always_comb
    begin
        for (int j = 0; j < 32; j++) begin
            skip[j] = seq[j] ? (cfg.one_space_us == '0) : (cfg.zero_space_us == '0);
        end
    end

    assign tick_inc  = {1'b0, tick_reg} + 17'd1;
    assign cycle_inc = {1'b0, cycle_reg} + 11'd1;
    assign b_inc     = bit_reg + 6'd1;
    assign space_len = (phase_reg == nectx_pkg::PH_LEAD_SPACE) ? cfg.leader_space_us :
                       (seq[bit_reg[4:0]] ? cfg.one_space_us : cfg.zero_space_us);
    assign mark_len  = (phase_reg == nectx_pkg::PH_LEAD_MARK) ? cfg.leader_mark_cycles :
                       cfg.bit_mark_cycles;
    assign level_cur = nectx_pkg::is_mark(phase_reg) && ({8'd0, cfg.carrier_high_us} > tick_reg);

    // Phase end / start: which phase to enter, item status and counter updates
    always_comb
    begin
        req_en     = 1'b0;
        req_ph     = nectx_pkg::PH_IDLE;
        req_b      = bit_reg;
        tick_next  = tick_reg;
        cycle_next = cycle_reg;
        status     = nectx_pkg::ST_NONE;
        frame_next = frame_reg;
        last_next  = last_reg;
        if (op) begin
            if (!cfg.enable) begin
                status = nectx_pkg::ST_REJ_DISABLED;
            end else if (phase_reg != nectx_pkg::PH_IDLE) begin
                status = nectx_pkg::ST_REJ_BUSY;
            end else begin
                status     = nectx_pkg::ST_STARTED;
                frame_next = code;
                last_next  = code;
                req_en     = 1'b1;
                req_ph     = nectx_pkg::PH_LEAD_MARK;
                req_b      = '0;
            end
        end else if (phase_reg != nectx_pkg::PH_IDLE) begin
            if (nectx_pkg::is_mark(phase_reg)) begin
                if (tick_inc >= {9'd0, cfg.carrier_period_us}) begin
                    tick_next = '0;
                    if (cycle_inc >= {1'b0, mark_len}) begin
                        req_en = 1'b1;
                    end else begin
                        cycle_next = cycle_inc[nectx_pkg::CYCLE_W-1:0];
                    end
                end else begin
                    tick_next = tick_inc[nectx_pkg::TICK_W-1:0];
                end
            end else begin
                if (tick_inc >= {1'b0, space_len}) begin
                    req_en = 1'b1;
                end else begin
                    tick_next = tick_inc[nectx_pkg::TICK_W-1:0];
                end
            end
            if (req_en) begin
                case (phase_reg)
                    nectx_pkg::PH_LEAD_MARK:  req_ph = nectx_pkg::PH_LEAD_SPACE;
                    nectx_pkg::PH_LEAD_SPACE:
                    begin
                        req_ph = nectx_pkg::PH_BIT_MARK;
                        req_b  = '0;
                    end
                    nectx_pkg::PH_BIT_MARK:   req_ph = nectx_pkg::PH_BIT_SPACE;
                    nectx_pkg::PH_BIT_SPACE:
                    begin
                        req_b  = b_inc;
                        req_ph = b_inc[5] ? nectx_pkg::PH_STOP_MARK : nectx_pkg::PH_BIT_MARK;
                    end
                    default:                  req_ph = nectx_pkg::PH_IDLE;
                endcase
            end
        end
    end

    // Skip phases of zero length
    always_comb
    begin
        ent_ph = req_ph;
        ent_b  = req_b;
        cand   = '0;
        found  = 1'b0;
        first  = '0;
        if (ent_ph == nectx_pkg::PH_LEAD_MARK && cfg.leader_mark_cycles == '0) begin
            ent_ph = nectx_pkg::PH_LEAD_SPACE;
        end
        if (ent_ph == nectx_pkg::PH_LEAD_SPACE && cfg.leader_space_us == '0) begin
            ent_ph = nectx_pkg::PH_BIT_MARK;
            ent_b  = '0;
        end
        if (ent_ph == nectx_pkg::PH_BIT_SPACE && skip[ent_b[4:0]]) begin
            ent_b  = ent_b + 6'd1;
            ent_ph = ent_b[5] ? nectx_pkg::PH_STOP_MARK : nectx_pkg::PH_BIT_MARK;
        end
        if (ent_ph == nectx_pkg::PH_BIT_MARK && cfg.bit_mark_cycles == '0) begin
            cand = ~skip & ~((32'd1 << ent_b[4:0]) - 32'd1);
            for (int j = 31; j >= 0; j--) begin
                if (cand[j]) begin
                    found = 1'b1;
                    first = 5'(j);
                end
            end
            if (found) begin
                ent_ph = nectx_pkg::PH_BIT_SPACE;
                ent_b  = {1'b0, first};
            end else begin
                ent_ph = nectx_pkg::PH_STOP_MARK;
                ent_b  = 6'd32;
            end
        end
        if (ent_ph == nectx_pkg::PH_STOP_MARK && cfg.bit_mark_cycles == '0) begin
            ent_ph = nectx_pkg::PH_IDLE;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        if (req_en) begin
            phase_next = ent_ph;
            bit_next   = ent_b;
        end
    end

    assign level_next = nectx_pkg::is_mark(phase_next) &&
                        ({8'd0, cfg.carrier_high_us} > (req_en ? '0 : tick_next));

    assign res.ir_level      = op ? level_next : level_cur;
    assign res.busy_res      = (phase_next != nectx_pkg::PH_IDLE);
    assign res.status        = status;
    assign res.last_code_out = last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= nectx_pkg::PH_IDLE;
            tick_reg  <= '0;
            cycle_reg <= '0;
            bit_reg   <= '0;
            frame_reg <= '0;
            last_reg  <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            tick_reg  <= req_en ? '0 : tick_next;
            cycle_reg <= req_en ? '0 : cycle_next;
            bit_reg   <= bit_next;
            frame_reg <= frame_next;
            last_reg  <= last_next;
        end
    end

endmodule

>>> sv/nec_ir_transmitter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_transmitter_unit
// NEC IR frame transmitter paced by one-microsecond tick transfers.
// ----------------------------------------------------------------------------
//  Channel   Dir   Signals                      Content
//  s_*       in    tvalid tready tdata tuser     tick or start item
//  m_*       out   tvalid tready tdata           result of one item
//  cfg_*     in    we index data                 register write
//
//  One item per cycle sustained while m_tready stays high; an item passes the
//  input register, then the state update and result register in the same edge.
//  Reset clears the frame state and loads register defaults.
//  A stalled m_tready holds the result; the input register keeps taking one
//  more transfer, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module nec_ir_transmitter_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [31:0]                           s_tdata,   // [31:0] code
    input  logic                                  s_tuser,   // [0] op
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [0] ir_level, [1] busy_res, [3:2] status, [35:4] last_code_out, [39:36] zero
    output logic [nectx_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                  cfg_we,
    input  logic [nectx_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nectx_pkg::CFG_DATA_W-1:0]      cfg_data
);

    nectx_pkg::cfg_t     cfg_reg;
    nectx_pkg::result_t  res;
    logic                in_valid_reg;
    logic                in_op_reg;
    logic [31:0]         in_code_reg;
    logic                out_valid_reg;
    logic [nectx_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                step;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.enable             <= 1'b0;
            cfg_reg.carrier_period_us  <= nectx_pkg::RST_CARRIER_PER;
            cfg_reg.carrier_high_us    <= nectx_pkg::RST_CARRIER_HIGH;
            cfg_reg.leader_mark_cycles <= nectx_pkg::RST_LEAD_MARK;
            cfg_reg.leader_space_us    <= nectx_pkg::RST_LEAD_SPACE;
            cfg_reg.bit_mark_cycles    <= nectx_pkg::RST_BIT_MARK;
            cfg_reg.zero_space_us      <= nectx_pkg::RST_ZERO_SPACE;
            cfg_reg.one_space_us       <= nectx_pkg::RST_ONE_SPACE;
        end else if (cfg_we) begin
            case (nectx_pkg::cfg_index_t'(cfg_index))
                nectx_pkg::REG_ENABLE:       cfg_reg.enable             <= cfg_data[0];
                nectx_pkg::REG_CARRIER_PER:  cfg_reg.carrier_period_us  <= cfg_data[7:0];
                nectx_pkg::REG_CARRIER_HIGH: cfg_reg.carrier_high_us    <= cfg_data[7:0];
                nectx_pkg::REG_LEAD_MARK:    cfg_reg.leader_mark_cycles <= cfg_data[9:0];
                nectx_pkg::REG_LEAD_SPACE:   cfg_reg.leader_space_us    <= cfg_data;
                nectx_pkg::REG_BIT_MARK:     cfg_reg.bit_mark_cycles    <= cfg_data[9:0];
                nectx_pkg::REG_ZERO_SPACE:   cfg_reg.zero_space_us      <= cfg_data;
                nectx_pkg::REG_ONE_SPACE:    cfg_reg.one_space_us       <= cfg_data;
                default:                     cfg_reg.enable             <= cfg_reg.enable;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser;
            in_code_reg <= s_tdata;
        end
        if (step) begin
            out_data_reg <= {4'd0, res.last_code_out, res.status, res.busy_res, res.ir_level};
        end
    end

    nectx_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .op    (in_op_reg),
        .code  (in_code_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

endmodule
